>>> rtl/mbr_pkg.sv
// Shared types, constants and CRC helpers for the Modbus RTU read master.
`timescale 1ns / 1ps
`default_nettype none
package mbr_pkg;

  // Protocol limits and constants
  localparam logic [6:0]  MAX_REGS   = 7'd125;
  localparam logic [8:0]  COUNT_MAX  = 9'd511;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [8:0]  HDR_BYTES  = 9'd3;
  localparam logic [8:0]  MIN_FRAME  = 9'd5;

  // Request frame positions that carry the CRC
  localparam logic [2:0]  REQ_CRC_LO = 3'd6;
  localparam logic [2:0]  REQ_CRC_HI = 3'd7;

  // Config reset values
  localparam logic [7:0]  RST_SLAVE  = 8'd1;
  localparam logic [2:0]  RST_FUNC   = 3'd3;
  localparam logic [15:0] RST_START  = 16'd0;
  localparam logic [6:0]  RST_COUNT  = 7'd1;

  typedef enum logic [1:0] {
    KIND_REQ    = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_EXCEPT = 2'd2,
    ST_CRC    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SLAVE = 2'd0,
    CFG_FUNC  = 2'd1,
    CFG_START = 2'd2,
    CFG_COUNT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [2:0]  function_code;
    logic [15:0] start_register;
    logic [6:0]  register_count;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  // One queued unit of output work: a request frame, or a value and/or a status
  typedef struct packed {
    logic        is_req;
    logic        val_valid;
    logic [15:0] value;
    logic [6:0]  reg_index;
    logic        st_valid;
    status_t     status;
  } desc_t;

  // CRC-16/Modbus, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Register count clamped to the protocol maximum
  function automatic logic [6:0] eff_count(input logic [6:0] c);
    return (c > MAX_REGS) ? MAX_REGS : c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mbr_if.sv
// Valid/ready channel interfaces for command beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface mbr_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source(output valid, command, rx_byte, frame_end, input ready);
  modport sink(input valid, command, rx_byte, frame_end, output ready);
endinterface

interface mbr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] value;
  logic [6:0]  reg_index;
  logic [1:0]  status;
  logic        last;

  modport source(output valid, kind, value, reg_index, status, last, input ready);
  modport sink(input valid, kind, value, reg_index, status, last, output ready);
endinterface
`default_nettype wire

>>> rtl/modbus_rtu_read_master_top.sv
// Top level of the Modbus RTU read master: config registers and datapath wiring.
// Throughput: one response byte per cycle while the work queue has room.
// A request emits 8 result beats, one per cycle while the result side is ready.
// The command side stays ready while the two-entry work queue has room.
// Reset (synchronous, rst high): config to defaults, receive state cleared, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_read_master_top (
  input  wire logic        clk,
  input  wire logic        rst,
  mbr_cmd_if.sink          cmd,
  mbr_res_if.source        res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  mbr_pkg::cfg_t  cfg;
  mbr_pkg::item_t item;
  mbr_pkg::desc_t rx_desc;
  mbr_pkg::desc_t head;
  logic           rx_push;
  logic           head_valid;
  logic           q_full;
  logic           pop;
  logic           accept;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;
  assign item      = '{command: cmd.command, rx_byte: cmd.rx_byte, frame_end: cmd.frame_end};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address  <= mbr_pkg::RST_SLAVE;
      cfg.function_code  <= mbr_pkg::RST_FUNC;
      cfg.start_register <= mbr_pkg::RST_START;
      cfg.register_count <= mbr_pkg::RST_COUNT;
    end else if (cfg_we) begin
      unique case (mbr_pkg::cfg_idx_t'(cfg_index))
        mbr_pkg::CFG_SLAVE: cfg.slave_address  <= cfg_data[7:0];
        mbr_pkg::CFG_FUNC:  cfg.function_code  <= cfg_data[2:0];
        mbr_pkg::CFG_START: cfg.start_register <= cfg_data;
        mbr_pkg::CFG_COUNT: cfg.register_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  mbr_rx u_rx (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (item),
    .desc   (rx_desc),
    .push   (rx_push)
  );

  mbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rx_push),
    .din       (rx_desc),
    .pop       (pop),
    .dout      (head),
    .not_empty (head_valid),
    .full      (q_full)
  );

  mbr_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .res        (res)
  );

endmodule
`default_nettype wire

>>> rtl/mbr_rx.sv
// Receive frame tracker: per-byte state update, CRC and status checks.
`timescale 1ns / 1ps
`default_nettype none
module mbr_rx (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mbr_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire mbr_pkg::item_t item,
  output mbr_pkg::desc_t     desc,
  output logic               push
);

  logic [8:0]  byte_count, byte_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  tail_bytes [2];
  logic [7:0]  tail_bytes_next [2];
  logic        address_ok, address_ok_next;
  logic        exception_seen, exception_seen_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;

  logic [6:0]  cnt;
  logic [8:0]  data_end;
  logic [8:0]  expect_len;
  logic [8:0]  off;
  logic [7:0]  exc_code;

  assign cnt        = mbr_pkg::eff_count(cfg.register_count);
  assign data_end   = mbr_pkg::HDR_BYTES + {1'b0, cnt, 1'b0};
  assign expect_len = mbr_pkg::MIN_FRAME + {1'b0, cnt, 1'b0};
  assign off        = byte_count - mbr_pkg::HDR_BYTES;
  assign exc_code   = {5'b0, cfg.function_code} | mbr_pkg::EXC_FLAG;

  // Next state and output work for one accepted beat
  always_comb begin
    byte_count_next     = byte_count;
    crc_accum_next      = crc_accum;
    tail_bytes_next[0]  = tail_bytes[0];
    tail_bytes_next[1]  = tail_bytes[1];
    address_ok_next     = address_ok;
    exception_seen_next = exception_seen;
    high_byte_hold_next = high_byte_hold;
    push                = 1'b0;
    desc                = '0;

    if (accept) begin
      if (!item.command) begin
        // request: emit frame, restart receive side
        push                = 1'b1;
        desc.is_req         = 1'b1;
        byte_count_next     = '0;
        crc_accum_next      = mbr_pkg::CRC_INIT;
        tail_bytes_next[0]  = '0;
        tail_bytes_next[1]  = '0;
        address_ok_next     = 1'b0;
        exception_seen_next = 1'b0;
        high_byte_hold_next = '0;
      end else begin
        if (byte_count == 9'd0) begin
          address_ok_next = (item.rx_byte == cfg.slave_address);
        end else if (byte_count == 9'd1) begin
          exception_seen_next = (item.rx_byte == exc_code);
        end else if (byte_count >= mbr_pkg::HDR_BYTES && byte_count < data_end) begin
          if (!off[0]) begin
            high_byte_hold_next = item.rx_byte;
          end else begin
            push           = 1'b1;
            desc.val_valid = 1'b1;
            desc.value     = {high_byte_hold, item.rx_byte};
            desc.reg_index = off[7:1];
          end
        end

        // CRC trails by two bytes so the received CRC is never folded in
        if (byte_count >= 9'd2) begin
          crc_accum_next = mbr_pkg::crc_byte(crc_accum, tail_bytes[0]);
        end
        tail_bytes_next[0] = tail_bytes[1];
        tail_bytes_next[1] = item.rx_byte;
        if (byte_count != mbr_pkg::COUNT_MAX) begin
          byte_count_next = byte_count + 9'd1;
        end

        if (item.frame_end) begin
          push          = 1'b1;
          desc.st_valid = 1'b1;
          if (byte_count_next < mbr_pkg::MIN_FRAME || !address_ok_next) begin
            desc.status = mbr_pkg::ST_FORMAT;
          end else if (exception_seen_next) begin
            desc.status = mbr_pkg::ST_EXCEPT;
          end else if (byte_count_next != expect_len) begin
            desc.status = mbr_pkg::ST_FORMAT;
          end else if (crc_accum_next != {item.rx_byte, tail_bytes[1]}) begin
            desc.status = mbr_pkg::ST_CRC;
          end else begin
            desc.status = mbr_pkg::ST_OK;
          end
          byte_count_next     = '0;
          crc_accum_next      = mbr_pkg::CRC_INIT;
          tail_bytes_next[0]  = '0;
          tail_bytes_next[1]  = '0;
          address_ok_next     = 1'b0;
          exception_seen_next = 1'b0;
          high_byte_hold_next = '0;
        end
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      crc_accum      <= mbr_pkg::CRC_INIT;
      tail_bytes[0]  <= '0;
      tail_bytes[1]  <= '0;
      address_ok     <= 1'b0;
      exception_seen <= 1'b0;
      high_byte_hold <= '0;
    end else begin
      byte_count     <= byte_count_next;
      crc_accum      <= crc_accum_next;
      tail_bytes[0]  <= tail_bytes_next[0];
      tail_bytes[1]  <= tail_bytes_next[1];
      address_ok     <= address_ok_next;
      exception_seen <= exception_seen_next;
      high_byte_hold <= high_byte_hold_next;
    end
  end

  // A request restarts the receive side
  a_req_clears: assert property (@(posedge clk) disable iff (rst)
    accept && !item.command |=> byte_count == 9'd0 && crc_accum == mbr_pkg::CRC_INIT)
    else $error("request did not clear receive state");

  // A frame end always yields a status
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    accept && item.command && item.frame_end |-> push && desc.st_valid)
    else $error("frame end without status");

endmodule
`default_nettype wire

>>> rtl/mbr_queue.sv
// Two-entry work queue between the receive tracker and the result emitter.
`timescale 1ns / 1ps
`default_nettype none
module mbr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mbr_pkg::desc_t din,
  input  wire logic           pop,
  output mbr_pkg::desc_t      dout,
  output logic                not_empty,
  output logic                full
);

  mbr_pkg::desc_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign dout      = entries[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("work queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("work queue underflow");

endmodule
`default_nettype wire

>>> rtl/mbr_tx.sv
// Result emitter: expands queued work into result beats, builds request frames.
`timescale 1ns / 1ps
`default_nettype none
module mbr_tx (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mbr_pkg::cfg_t  cfg,
  input  wire mbr_pkg::desc_t head,
  input  wire logic           head_valid,
  output logic                pop,
  mbr_res_if.source           res
);

  logic [2:0]  beat;
  logic [15:0] crc;
  logic [15:0] crc_cur;
  logic [7:0]  req_byte;
  logic        fire;

  assign crc_cur = (beat == 3'd0) ? mbr_pkg::CRC_INIT : crc;

  // Request frame byte for the current beat
  always_comb begin
    case (beat)
      3'd0:                req_byte = cfg.slave_address;
      3'd1:                req_byte = {5'b0, cfg.function_code};
      3'd2:                req_byte = cfg.start_register[15:8];
      3'd3:                req_byte = cfg.start_register[7:0];
      3'd4:                req_byte = 8'h00;
      3'd5:                req_byte = {1'b0, mbr_pkg::eff_count(cfg.register_count)};
      mbr_pkg::REQ_CRC_LO: req_byte = crc[7:0];
      default:             req_byte = crc[15:8];
    endcase
  end

  // Result beat fields
  always_comb begin
    res.valid     = head_valid;
    res.kind      = mbr_pkg::KIND_STATUS;
    res.value     = '0;
    res.reg_index = '0;
    res.status    = mbr_pkg::ST_OK;
    res.last      = 1'b1;
    if (head.is_req) begin
      res.kind  = mbr_pkg::KIND_REQ;
      res.value = {8'h00, req_byte};
      res.last  = (beat == mbr_pkg::REQ_CRC_HI);
    end else if (head.val_valid && beat == 3'd0) begin
      res.kind      = mbr_pkg::KIND_VALUE;
      res.value     = head.value;
      res.reg_index = head.reg_index;
      res.last      = !head.st_valid;
    end else begin
      res.status = head.status;
    end
  end

  assign fire = res.valid && res.ready;
  assign pop  = fire && res.last;

  // Beat counter within the current unit of work
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else if (fire) begin
      beat <= res.last ? 3'd0 : 3'(beat + 3'd1);
    end
  end

  // Request CRC, one byte per emitted beat before the CRC beats
  always_ff @(posedge clk) begin
    if (fire && head.is_req && beat < mbr_pkg::REQ_CRC_LO) begin
      crc <= mbr_pkg::crc_byte(crc_cur, req_byte);
    end
  end

  a_beat_restart: assert property (@(posedge clk) disable iff (rst)
    fire && res.last |=> beat == 3'd0)
    else $error("beat counter not restarted after last beat");

  a_rx_two_beats: assert property (@(posedge clk) disable iff (rst)
    head_valid && !head.is_req |-> beat <= 3'd1)
    else $error("receive work ran past two beats");

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for the Modbus RTU read master: random handshakes, bit-exact output prediction.
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int TAIL_CYCLES  = 8;
  localparam int IDLE_PCT     = 35;
  localparam int REQ_LEN      = 8;
  localparam int HEADER_LEN   = 3;
  localparam int MIN_LEN      = 5;
  localparam int REG_LIMIT    = 125;
  localparam int SET_BEATS    = 8;
  localparam logic [8:0]  LEN_SAT   = 9'd511;
  localparam logic [7:0]  EXC_BIT   = 8'h80;
  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] CRC_RPOLY = 16'hA001;
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_BYTE    = 1'b1;

  // Ways a generated reply frame can be damaged
  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_EXCEPTION,
    FR_SHORT,
    FR_WRONG_ADDR
  } frame_flaw_t;

  typedef struct packed {
    mbr_pkg::kind_t   kind;
    logic [15:0]      value;
    logic [6:0]       reg_index;
    mbr_pkg::status_t status;
    logic             last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  mbr_cmd_if cmd_ch();
  mbr_res_if res_ch();

  modbus_rtu_read_master_top dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Command beats waiting to be offered, and output beats the master still owes
  mbr_pkg::item_t cmd_beats[$];
  out_beat_t      outputs_owed[$];
  mbr_pkg::item_t next_beat;

  logic steady = 1'b0;
  logic cmd_fire = 1'b0;
  int   hold_req = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   queued = 0;
  int   errors = 0;
  int   beats_in = 0;
  int   beats_out = 0;
  int   cfg_writes = 0;
  int   cycles = 0;

  // Shadow of the master: settings and receive state
  logic [7:0]  m_slave;
  logic [2:0]  m_func;
  logic [15:0] m_start;
  logic [6:0]  m_count;
  logic [8:0]  rx_len;
  logic [15:0] rx_crc;
  logic [7:0]  tail_lo;
  logic [7:0]  tail_hi;
  logic [7:0]  hi_hold;
  logic        addr_match;
  logic        exc_match;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-16/Modbus, reflected, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) begin
      if (r[0]) r = {1'b0, r[15:1]} ^ CRC_RPOLY;
      else r = {1'b0, r[15:1]};
    end
    return r;
  endfunction

  function automatic int regs_expected(input logic [6:0] c);
    return (int'(c) > REG_LIMIT) ? REG_LIMIT : int'(c);
  endfunction

  task automatic clear_receive();
    rx_len = 9'd0;
    rx_crc = CRC_SEED;
    tail_lo = 8'h00;
    tail_hi = 8'h00;
    hi_hold = 8'h00;
    addr_match = 1'b0;
    exc_match = 1'b0;
  endtask

  // Output beats caused by one accepted command beat
  task automatic master_outputs(input mbr_pkg::item_t it);
    int               cnt;
    int               pos;
    logic [7:0]       req [REQ_LEN];
    logic [15:0]      c;
    mbr_pkg::status_t st;
    cnt = regs_expected(m_count);
    if (it.command == CMD_REQUEST) begin
      req[0] = m_slave;
      req[1] = {5'd0, m_func};
      req[2] = m_start[15:8];
      req[3] = m_start[7:0];
      req[4] = 8'h00;
      req[5] = 8'(cnt);
      c = CRC_SEED;
      for (int i = 0; i < REQ_LEN - 2; i++) c = crc16_step(c, req[i]);
      req[6] = c[7:0];
      req[7] = c[15:8];
      for (int i = 0; i < REQ_LEN; i++)
        outputs_owed.push_back('{mbr_pkg::KIND_REQ, {8'h00, req[i]}, 7'd0,
                                 mbr_pkg::ST_OK, i == REQ_LEN - 1});
      clear_receive();
    end else begin
      pos = int'(rx_len);
      if (pos == 0) addr_match = (it.rx_byte == m_slave);
      else if (pos == 1) exc_match = (it.rx_byte == ({5'd0, m_func} | EXC_BIT));
      else if (pos >= HEADER_LEN && pos < HEADER_LEN + 2 * cnt) begin
        // big-endian pair: high byte held, value out on the low byte
        if ((pos - HEADER_LEN) % 2 == 0) hi_hold = it.rx_byte;
        else outputs_owed.push_back('{mbr_pkg::KIND_VALUE, {hi_hold, it.rx_byte},
                                      7'((pos - HEADER_LEN) / 2), mbr_pkg::ST_OK,
                                      !it.frame_end});
      end
      // CRC runs two bytes behind so the trailing CRC itself is left out
      if (pos >= 2) rx_crc = crc16_step(rx_crc, tail_lo);
      tail_lo = tail_hi;
      tail_hi = it.rx_byte;
      if (rx_len != LEN_SAT) rx_len = rx_len + 9'd1;
      if (it.frame_end) begin
        if (int'(rx_len) < MIN_LEN || !addr_match) st = mbr_pkg::ST_FORMAT;
        else if (exc_match) st = mbr_pkg::ST_EXCEPT;
        else if (int'(rx_len) != MIN_LEN + 2 * cnt) st = mbr_pkg::ST_FORMAT;
        else if (rx_crc != {tail_hi, tail_lo}) st = mbr_pkg::ST_CRC;
        else st = mbr_pkg::ST_OK;
        outputs_owed.push_back('{mbr_pkg::KIND_STATUS, 16'h0000, 7'd0, st, 1'b1});
        clear_receive();
      end
    end
  endtask

  // Sample both channels and the config port; predict and check
  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (rst) begin
      cmd_fire <= 1'b0;
      m_slave = 8'd1;
      m_func = 3'd3;
      m_start = 16'h0000;
      m_count = 7'd1;
      clear_receive();
    end else begin
      cmd_fire <= cmd_ch.valid && cmd_ch.ready;
      if (cfg_we) begin
        case (mbr_pkg::cfg_idx_t'(cfg_index))
          mbr_pkg::CFG_SLAVE: m_slave = cfg_data[7:0];
          mbr_pkg::CFG_FUNC:  m_func = cfg_data[2:0];
          mbr_pkg::CFG_START: m_start = cfg_data;
          mbr_pkg::CFG_COUNT: m_count = cfg_data[6:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        beats_in++;
        master_outputs('{cmd_ch.command, cmd_ch.rx_byte, cmd_ch.frame_end});
      end
      if (res_ch.valid && res_ch.ready) begin
        beats_out++;
        got = {res_ch.kind, res_ch.value, res_ch.reg_index, res_ch.status, res_ch.last};
        if (outputs_owed.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind=%0d value=%h index=%0d status=%0d last=%b",
                   $time, got.kind, got.value, got.reg_index, got.status, got.last);
        end else begin
          want = outputs_owed.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected kind=%0d value=%h index=%0d status=%0d last=%b",
                     $time, want.kind, want.value, want.reg_index, want.status, want.last);
            $display("%0t:   actual kind=%0d value=%h index=%0d status=%0d last=%b",
                     $time, got.kind, got.value, got.reg_index, got.status, got.last);
          end
        end
      end
    end
  end

  // Command driver: holds a beat until taken, idles at random between beats unless steady
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_fire) begin
      if (cmd_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_beat = cmd_beats.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= next_beat.command;
        cmd_ch.rx_byte <= next_beat.rx_byte;
        cmd_ch.frame_end <= next_beat.frame_end;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls unless steady, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_done != hold_req) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d beats still owed",
               $time, cycles, outputs_owed.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_beat(input logic c, input logic [7:0] b, input logic e);
    cmd_beats.push_back('{c, b, e});
    queued++;
  endtask

  task automatic queue_request();
    push_beat(CMD_REQUEST, 8'($urandom), 1'($urandom));
  endtask

  task automatic queue_noise(input int n);
    for (int k = 0; k < n; k++) push_beat(CMD_BYTE, 8'($urandom), k == n - 1);
  endtask

  // Reply frame: address, function, byte count, data, CRC low/high, optional junk tail (exception: code, no data)
  task automatic queue_reply(input logic [7:0] addr, input logic [7:0] fn, input int nregs,
                             input frame_flaw_t flaw, input int pad, input logic patterned);
    logic [7:0]  fr[$];
    logic [15:0] c;
    int          cut;
    fr.push_back(flaw == FR_WRONG_ADDR ? addr ^ (8'h01 << $urandom_range(7)) : addr);
    if (flaw == FR_EXCEPTION) begin
      fr.push_back(fn | EXC_BIT);
      fr.push_back(8'($urandom_range(1, 4)));
    end else begin
      fr.push_back(fn);
      fr.push_back(8'(2 * nregs));
      for (int k = 0; k < 2 * nregs; k++)
        fr.push_back(patterned ? ((k % 2 == 0) ? 8'hFF : 8'h00) : 8'($urandom));
    end
    c = CRC_SEED;
    foreach (fr[k]) c = crc16_step(c, fr[k]);
    if (flaw == FR_BAD_CRC) c = c ^ (16'h0001 << $urandom_range(15));
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    repeat (pad) fr.push_back(8'($urandom));
    if (flaw == FR_SHORT) begin
      cut = $urandom_range(1, MIN_LEN - 1);
      while (fr.size() > cut) void'(fr.pop_back());
    end
    foreach (fr[k]) push_beat(CMD_BYTE, fr[k], k == fr.size() - 1);
  endtask

  // Wait until every beat is sent and every owed output has come, then settle
  task automatic drain();
    while (cmd_beats.size() != 0 || cmd_ch.valid || outputs_owed.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input mbr_pkg::cfg_idx_t idx, input logic [15:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= 16'($urandom);
  endtask

  // Unused upper data bits get random fill; the master must ignore them
  task automatic set_config(input logic [7:0] slave, input logic [2:0] func,
                            input logic [15:0] start, input logic [6:0] count);
    write_reg(mbr_pkg::CFG_SLAVE, {8'($urandom), slave});
    write_reg(mbr_pkg::CFG_FUNC, {13'($urandom), func});
    write_reg(mbr_pkg::CFG_START, start);
    write_reg(mbr_pkg::CFG_COUNT, {9'($urandom), count});
  endtask

  initial begin
    logic [7:0]  slave;
    logic [2:0]  func;
    logic [6:0]  count;
    int          nregs;
    int          r;
    int          set_first;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_REQUEST;
    cmd_ch.rx_byte = 8'h00;
    cmd_ch.frame_end = 1'b0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mbr_pkg::CFG_SLAVE;
    cfg_data = 16'h0000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a reply before any request, under reset settings
    queue_reply(8'd1, 8'd3, 1, FR_GOOD, 0, 1'b1);
    push_beat(CMD_REQUEST, 8'hFF, 1'b1);
    drain();

    // Top of the address, start and count ranges; count above the limit gets clamped in the request
    set_config(8'hFF, 3'd4, 16'hFFFF, 7'd127);
    push_beat(CMD_REQUEST, 8'h00, 1'b0);
    queue_reply(8'hFF, 8'h04, 0, FR_EXCEPTION, 0, 1'b0);
    queue_reply(8'hFF, 8'h04, 0, FR_SHORT, 0, 1'b0);
    drain();

    // Bottom of the address, start and count ranges: zero count, odd function code, data past the count
    set_config(8'h00, 3'd7, 16'h0000, 7'd0);
    queue_request();
    queue_reply(8'h00, 8'h07, 0, FR_GOOD, 0, 1'b0);
    queue_reply(8'h00, 8'h07, 1, FR_GOOD, 0, 1'b1);
    drain();

    // Random sets: mostly clean replies, some damaged frames, noise and stray requests
    for (int s = 0; s < 5; s++) begin
      slave = 8'($urandom);
      func = ($urandom_range(9) == 0) ? 3'($urandom) : ($urandom_range(1) ? 3'd3 : 3'd4);
      count = (s == 3) ? 7'd0 : 7'($urandom_range(1, 6));
      set_config(slave, func, 16'($urandom), count);
      steady = (s == 1);
      if (s == 0) hold_req++;
      nregs = regs_expected(count);
      queue_request();
      set_first = queued;
      while (queued - set_first < SET_BEATS) begin
        r = $urandom_range(99);
        if (r < 58) queue_reply(slave, {5'd0, func}, nregs, FR_GOOD, 0, 1'b0);
        else if (r < 66) queue_reply(slave, {5'd0, func}, nregs, FR_BAD_CRC, 0, 1'b0);
        else if (r < 72) queue_reply(slave, {5'd0, func}, nregs, FR_EXCEPTION, 0, 1'b0);
        else if (r < 78) queue_reply(slave, {5'd0, func}, nregs, FR_SHORT, 0, 1'b0);
        else if (r < 84) queue_reply(slave, {5'd0, func}, nregs, FR_WRONG_ADDR, 0, 1'b0);
        else if (r < 89) queue_reply(slave, {5'd0, func}, nregs + 1, FR_GOOD, 0, 1'b0);
        else if (r < 94)
          queue_reply(slave, {5'd0, func}, nregs, FR_GOOD, $urandom_range(1, 3), 1'b0);
        else if (r < 97) queue_noise($urandom_range(1, 12));
        else queue_request();
      end
      drain();
    end
    steady = 1'b0;

    $display("covered %0d command beats over %0d register writes: requests, clean and damaged",
             beats_in, cfg_writes);
    $display("replies, exceptions, short frames and noise; %0d output beats checked",
             beats_out);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
